@@ hdl/rgld_pkg.sv @@
// ----------------------------------------------------------------------------
// rgld_pkg
// Shared types, codes and reset constants of the RSSI gate lap detector.
// ----------------------------------------------------------------------------
package rgld_pkg;

  localparam int unsigned HISTORY_DEPTH = 16;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned RSSI_W  = 8;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned CFG_IW  = 3;
  localparam int unsigned CFG_DW  = 32;
  localparam int unsigned ALPHA_W = 4;
  localparam int unsigned LOWRUN_W = 4;
  localparam int unsigned DOMRUN_W = 2;
  localparam int unsigned MAXPK_W = 16;
  localparam int unsigned SUM_W   = 12;

  localparam logic [ALPHA_W-1:0]  ALPHA_FULL   = 4'd10;
  localparam logic [LOWRUN_W-1:0] LOW_RUN_MAX  = 4'd15;
  localparam logic [DOMRUN_W-1:0] DOM_RUN_MAX  = 2'd3;
  localparam logic [DOMRUN_W-1:0] DOM_CONFIRM  = 2'd2;

  // floor(x / 10) == (x * 3277) >> 15 for every sum up to 255 * 10
  localparam logic [SUM_W-1:0]    DIV10_MUL    = 12'd3277;
  localparam int unsigned         DIV10_SHIFT  = 15;

  localparam logic [RSSI_W-1:0]   RST_ENTER    = 8'd120;
  localparam logic [RSSI_W-1:0]   RST_EXIT     = 8'd80;
  localparam logic [TIME_W-1:0]   RST_MIN_LAP  = 32'd0;
  localparam logic [ALPHA_W-1:0]  RST_ALPHA    = 4'd4;
  localparam logic [MAXPK_W-1:0]  RST_MAX_PEAK = 16'd500;
  localparam logic [RSSI_W-1:0]   RST_SAT      = 8'd25;
  localparam logic [LOWRUN_W-1:0] RST_CONFIRM  = 4'd2;

  typedef enum logic [CMD_W-1:0] {
    CmdSample = 2'd0,
    CmdStart  = 2'd1,
    CmdStop   = 2'd2,
    CmdRead   = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IW-1:0] {
    CfgEnter   = 3'd0,
    CfgExit    = 3'd1,
    CfgMinLap  = 3'd2,
    CfgAlpha   = 3'd3,
    CfgMaxPeak = 3'd4,
    CfgSat     = 3'd5,
    CfgConfirm = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [RSSI_W-1:0]   enter_level;
    logic [RSSI_W-1:0]   exit_level;
    logic [TIME_W-1:0]   min_lap_ms;
    logic [ALPHA_W-1:0]  alpha_tenths;
    logic [MAXPK_W-1:0]  max_peak_ms;
    logic [RSSI_W-1:0]   saturation_margin;
    logic [LOWRUN_W-1:0] exit_confirm_needed;
  } cfg_t;

  typedef struct packed {
    logic [RSSI_W-1:0] smoothed_rssi;
    logic              lap_done;
    logic [TIME_W-1:0] lap_time;
    logic [IDX_W-1:0]  lap_slot;
    logic [IDX_W-1:0]  laps_recorded;
    logic              is_read;
  } res_t;

  // Divide a weighted sum by ten with a reciprocal multiply.
  function automatic logic [RSSI_W-1:0] div10(input logic [SUM_W-1:0] x);
    logic [2*SUM_W-1:0] prod;
    prod = {{SUM_W{1'b0}}, x} * {{SUM_W{1'b0}}, DIV10_MUL};
    return prod[DIV10_SHIFT +: RSSI_W];
  endfunction

endpackage

@@ hdl/rgld_if.sv @@
// ----------------------------------------------------------------------------
// rgld_if
// Request and result channels of the lap detector, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rgld_req_if;
  logic                      valid;
  logic                      ready;
  logic [rgld_pkg::CMD_W-1:0]  command;
  logic [rgld_pkg::TIME_W-1:0] time_ms;
  logic [rgld_pkg::RSSI_W-1:0] rssi;
  logic                      dominant;
  logic [rgld_pkg::IDX_W-1:0]  lap_index;

  modport source (output valid, command, time_ms, rssi, dominant, lap_index, input ready);
  modport sink   (input valid, command, time_ms, rssi, dominant, lap_index, output ready);
endinterface

interface rgld_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [rgld_pkg::RSSI_W-1:0] smoothed_rssi;
  logic                      lap_done;
  logic [rgld_pkg::TIME_W-1:0] lap_time;
  logic [rgld_pkg::IDX_W-1:0]  lap_slot;
  logic [rgld_pkg::IDX_W-1:0]  laps_recorded;

  modport source (output valid, smoothed_rssi, lap_done, lap_time, lap_slot, laps_recorded,
                  input ready);
  modport sink   (input valid, smoothed_rssi, lap_done, lap_time, lap_slot, laps_recorded,
                  output ready);
endinterface

@@ hdl/rgld_history.sv @@
// ----------------------------------------------------------------------------
// rgld_history
// Lap time ring: synchronous memory with per-entry valid bits.
// ----------------------------------------------------------------------------
module rgld_history #(
  parameter int unsigned HistoryDepth = rgld_pkg::HISTORY_DEPTH,
  localparam int unsigned PtrW = (HistoryDepth > 1) ? $clog2(HistoryDepth) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clr_i,
  input  logic                        wr_i,
  input  logic [PtrW-1:0]             wr_idx_i,
  input  logic [rgld_pkg::TIME_W-1:0] wr_data_i,
  input  logic                        rd_i,
  input  logic [rgld_pkg::IDX_W-1:0]  rd_idx_i,
  output logic [rgld_pkg::TIME_W-1:0] rd_data_o
);

  logic [rgld_pkg::TIME_W-1:0] mem [HistoryDepth];
  logic [HistoryDepth-1:0]     valid_q;
  logic [rgld_pkg::TIME_W-1:0] rd_data_q;
  logic                        rd_hit_q;
  logic [PtrW-1:0]             rd_addr;
  logic                        in_range;

  assign in_range = ({{(32-rgld_pkg::IDX_W){1'b0}}, rd_idx_i} < 32'(HistoryDepth));
  assign rd_addr  = PtrW'(rd_idx_i);

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
    if (rd_i) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_hit_q <= 1'b0;
    end else begin
      if (clr_i) begin
        valid_q <= '0;
      end else if (wr_i) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
      if (rd_i) begin
        rd_hit_q <= in_range && valid_q[rd_addr];
      end
    end
  end

  // unwritten or out-of-range slots read as zero
  assign rd_data_o = rd_hit_q ? rd_data_q : '0;

endmodule

@@ hdl/rgld_core.sv @@
// ----------------------------------------------------------------------------
// rgld_core
// Average, peak capture and lap decision; one request per cycle while acc_i is high.
// ----------------------------------------------------------------------------
module rgld_core #(
  parameter int unsigned HistoryDepth = rgld_pkg::HISTORY_DEPTH,
  localparam int unsigned PtrW = (HistoryDepth > 1) ? $clog2(HistoryDepth) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        acc_i,
  input  logic [rgld_pkg::CMD_W-1:0]  command_i,
  input  logic [rgld_pkg::TIME_W-1:0] time_ms_i,
  input  logic [rgld_pkg::RSSI_W-1:0] rssi_i,
  input  logic                        dominant_i,
  input  rgld_pkg::cfg_t              cfg_i,
  output rgld_pkg::res_t              res_o,
  output logic                        clr_o,
  output logic                        wr_o,
  output logic [PtrW-1:0]             wr_idx_o,
  output logic                        rd_o
);

  localparam logic [PtrW-1:0] LastPos = PtrW'(HistoryDepth - 1);

  logic [rgld_pkg::RSSI_W-1:0]   avg_q, avg_d, pk_q, pk_d;
  logic                          run_q, run_d, wrap_q, wrap_d, pc_q, pc_d;
  logic [PtrW-1:0]               wpos_q, wpos_d;
  logic [rgld_pkg::TIME_W-1:0]   ps_q, ps_d, es_q, es_d, rb_q, rb_d, lb_q, lb_d;
  logic [rgld_pkg::LOWRUN_W-1:0] lr_q, lr_d;
  logic [rgld_pkg::DOMRUN_W-1:0] dr_q, dr_d;
  logic [rgld_pkg::ALPHA_W-1:0]  alpha;
  logic [rgld_pkg::SUM_W-1:0]    wsum;
  logic [rgld_pkg::TIME_W-1:0]   es1, ltime;
  logic [rgld_pkg::RSSI_W:0]     sat_lvl;
  logic                          first, go, pass, done, clr;
  rgld_pkg::cmd_e                cmd;

  assign cmd     = rgld_pkg::cmd_e'(command_i);
  assign alpha   = (cfg_i.alpha_tenths > rgld_pkg::ALPHA_FULL) ? rgld_pkg::ALPHA_FULL
                                                               : cfg_i.alpha_tenths;
  assign wsum    = ({4'd0, rssi_i} * {8'd0, alpha})
                 + ({4'd0, avg_q} * {8'd0, (rgld_pkg::ALPHA_FULL - alpha)});
  assign sat_lvl = {1'b0, cfg_i.enter_level} + {1'b0, cfg_i.saturation_margin};
  assign first   = (wpos_q == '0) && !wrap_q;
  assign go      = first || ((time_ms_i - lb_q) > cfg_i.min_lap_ms);

  always_comb begin
    avg_d  = avg_q;
    run_d  = run_q;
    wpos_d = wpos_q;
    wrap_d = wrap_q;
    pk_d   = pk_q;
    ps_d   = ps_q;
    es_d   = es_q;
    lr_d   = lr_q;
    dr_d   = dr_q;
    pc_d   = pc_q;
    rb_d   = rb_q;
    lb_d   = lb_q;
    es1    = es_q;
    pass   = 1'b0;
    done   = 1'b0;
    clr    = 1'b0;
    ltime  = '0;
    case (cmd)
      rgld_pkg::CmdSample: begin
        avg_d = rgld_pkg::div10(wsum);
        if (run_q) begin
          if (go) begin
            if (dominant_i && avg_d >= cfg_i.enter_level) begin
              es1 = (es_q == '0) ? time_ms_i : es_q;
              if ((time_ms_i - es1) > {16'd0, cfg_i.max_peak_ms}) begin
                // held too long: treat as ambient, restart the entry window
                pk_d = '0;
                ps_d = '0;
                dr_d = '0;
                pc_d = 1'b0;
                es_d = time_ms_i;
              end else begin
                es_d = es1;
                if (avg_d > pk_q) begin
                  pk_d = avg_d;
                  ps_d = time_ms_i;
                end
                if (dr_q < rgld_pkg::DOM_RUN_MAX) begin
                  dr_d = dr_q + 1'b1;
                end
                if (dr_d >= rgld_pkg::DOM_CONFIRM) begin
                  pc_d = 1'b1;
                end
              end
            end else if (!dominant_i && pk_q != '0 && !pc_q &&
                         {1'b0, rssi_i} >= sat_lvl && avg_d >= cfg_i.enter_level) begin
              // saturated front end: drop the unconfirmed peak
              pk_d = '0;
              ps_d = '0;
              dr_d = '0;
              es_d = '0;
            end else if (avg_d < cfg_i.enter_level) begin
              dr_d = '0;
              es_d = '0;
            end
          end
          if (pk_d <= cfg_i.exit_level) begin
            lr_d = '0;
          end else if (avg_d < pk_d && avg_d < cfg_i.exit_level) begin
            if (lr_q < rgld_pkg::LOW_RUN_MAX) begin
              lr_d = lr_q + 1'b1;
            end
            pass = (lr_d >= cfg_i.exit_confirm_needed);
          end else begin
            lr_d = '0;
          end
          if (pass) begin
            done   = 1'b1;
            ltime  = ps_d - (first ? rb_q : lb_q);
            wpos_d = (wpos_q == LastPos) ? '0 : wpos_q + 1'b1;
            if (wpos_q == LastPos) begin
              wrap_d = 1'b1;
            end
            lb_d = ps_d;
            pk_d = '0;
            ps_d = '0;
            es_d = '0;
            lr_d = '0;
            dr_d = '0;
            pc_d = 1'b0;
          end
        end
      end
      rgld_pkg::CmdStart, rgld_pkg::CmdStop: begin
        clr    = 1'b1;
        run_d  = (cmd == rgld_pkg::CmdStart);
        if (cmd == rgld_pkg::CmdStart) begin
          rb_d = time_ms_i;
          lb_d = time_ms_i;
        end
        wpos_d = '0;
        wrap_d = 1'b0;
        pk_d   = '0;
        ps_d   = '0;
        es_d   = '0;
        lr_d   = '0;
        dr_d   = '0;
        pc_d   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q  <= '0;
      run_q  <= 1'b0;
      wpos_q <= '0;
      wrap_q <= 1'b0;
      pk_q   <= '0;
      ps_q   <= '0;
      es_q   <= '0;
      lr_q   <= '0;
      dr_q   <= '0;
      pc_q   <= 1'b0;
      rb_q   <= '0;
      lb_q   <= '0;
    end else if (acc_i) begin
      avg_q  <= avg_d;
      run_q  <= run_d;
      wpos_q <= wpos_d;
      wrap_q <= wrap_d;
      pk_q   <= pk_d;
      ps_q   <= ps_d;
      es_q   <= es_d;
      lr_q   <= lr_d;
      dr_q   <= dr_d;
      pc_q   <= pc_d;
      rb_q   <= rb_d;
      lb_q   <= lb_d;
    end
  end

  assign clr_o    = acc_i && clr;
  assign wr_o     = acc_i && done;
  assign wr_idx_o = wpos_q;
  assign rd_o     = acc_i && (cmd == rgld_pkg::CmdRead);

  assign res_o.smoothed_rssi = avg_d;
  assign res_o.lap_done      = done;
  assign res_o.lap_time      = ltime;
  assign res_o.lap_slot      = done ? rgld_pkg::IDX_W'(wpos_q) : '0;
  assign res_o.laps_recorded = rgld_pkg::IDX_W'(wpos_d);
  assign res_o.is_read       = (cmd == rgld_pkg::CmdRead);

endmodule

@@ hdl/rssi_gate_lap_detector.sv @@
// ----------------------------------------------------------------------------
// rssi_gate_lap_detector
// Gate crossing detector with lap time history, top level.
// ----------------------------------------------------------------------------
// Takes one request per cycle and returns one result per request, in the cycle
// after acceptance, from an output register; a new request is taken while that
// result waits as long as the result is taken in the same cycle. The lap ring
// is a synchronous memory whose registered read feeds read-command results;
// start and stop clear it at once through per-entry valid bits.
module rssi_gate_lap_detector #(
  parameter int unsigned HistoryDepth = rgld_pkg::HISTORY_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rgld_pkg::CFG_IW-1:0]  cfg_idx_i,
  input  logic [rgld_pkg::CFG_DW-1:0]  cfg_wdata_i,
  rgld_req_if.sink                     req_i,
  rgld_rsp_if.source                   rsp_o
);

  localparam int unsigned PtrW = (HistoryDepth > 1) ? $clog2(HistoryDepth) : 1;

  rgld_pkg::cfg_t cfg_q;
  rgld_pkg::res_t res, res_q;
  logic           out_valid_q, acc, clr, wr, rd;
  logic [PtrW-1:0]             wr_idx;
  logic [rgld_pkg::TIME_W-1:0] rd_data;

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign acc         = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enter_level         <= rgld_pkg::RST_ENTER;
      cfg_q.exit_level          <= rgld_pkg::RST_EXIT;
      cfg_q.min_lap_ms          <= rgld_pkg::RST_MIN_LAP;
      cfg_q.alpha_tenths        <= rgld_pkg::RST_ALPHA;
      cfg_q.max_peak_ms         <= rgld_pkg::RST_MAX_PEAK;
      cfg_q.saturation_margin   <= rgld_pkg::RST_SAT;
      cfg_q.exit_confirm_needed <= rgld_pkg::RST_CONFIRM;
    end else if (cfg_we_i) begin
      case (rgld_pkg::cfg_idx_e'(cfg_idx_i))
        rgld_pkg::CfgEnter:   cfg_q.enter_level         <= cfg_wdata_i[7:0];
        rgld_pkg::CfgExit:    cfg_q.exit_level          <= cfg_wdata_i[7:0];
        rgld_pkg::CfgMinLap:  cfg_q.min_lap_ms          <= cfg_wdata_i;
        rgld_pkg::CfgAlpha:   cfg_q.alpha_tenths        <= cfg_wdata_i[3:0];
        rgld_pkg::CfgMaxPeak: cfg_q.max_peak_ms         <= cfg_wdata_i[15:0];
        rgld_pkg::CfgSat:     cfg_q.saturation_margin   <= cfg_wdata_i[7:0];
        rgld_pkg::CfgConfirm: cfg_q.exit_confirm_needed <= cfg_wdata_i[3:0];
        default: begin
        end
      endcase
    end
  end

  rgld_core #(.HistoryDepth(HistoryDepth)) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .command_i  (req_i.command),
    .time_ms_i  (req_i.time_ms),
    .rssi_i     (req_i.rssi),
    .dominant_i (req_i.dominant),
    .cfg_i      (cfg_q),
    .res_o      (res),
    .clr_o      (clr),
    .wr_o       (wr),
    .wr_idx_o   (wr_idx),
    .rd_o       (rd)
  );

  rgld_history #(.HistoryDepth(HistoryDepth)) u_history (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (clr),
    .wr_i      (wr),
    .wr_idx_i  (wr_idx),
    .wr_data_i (res.lap_time),
    .rd_i      (rd),
    .rd_idx_i  (req_i.lap_index),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      out_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_q <= res;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.smoothed_rssi = res_q.smoothed_rssi;
  assign rsp_o.lap_done      = res_q.lap_done;
  assign rsp_o.lap_time      = res_q.is_read ? rd_data : res_q.lap_time;
  assign rsp_o.lap_slot      = res_q.lap_slot;
  assign rsp_o.laps_recorded = res_q.laps_recorded;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> rsp_o.valid)
    else $error("accepted request produced no result");

  a_no_write_on_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr && clr))
    else $error("history write and clear in one cycle");

  a_write_needs_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr || clr || rd) |-> acc)
    else $error("history access without an accepted request");

endmodule
